// ----- rtl/core/bblur_pkg.sv -----
// Shared types, constants and the reciprocal table of the edge-aware 3x3 box blur.
// Used by every module of the block but bblur_ram; depends on nothing.
`default_nettype none

package bblur_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam int FW_W      = 11;
    localparam int FH_W      = 13;
    localparam int CFG_DW    = 13;
    localparam int CFG_IW    = 1;
    localparam int FW_RESET  = 640;
    localparam int FH_RESET  = 480;

    localparam logic [CFG_IW-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IW-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    localparam int CH_W      = 8;
    localparam int CSUM_W    = 10;
    localparam int SUM_W     = 12;
    localparam int CNT_W     = 4;
    localparam int NUM_W     = 13;
    localparam int RCP_W     = 17;
    localparam int RCP_SHIFT = 17;
    localparam int PROD_W    = NUM_W + RCP_W;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int PEND_W     = 4;

    typedef struct packed {
        logic            command;
        logic [CH_W-1:0] red_in;
        logic [CH_W-1:0] green_in;
        logic [CH_W-1:0] blue_in;
    } t_pix_in;

    typedef struct packed {
        logic [CH_W-1:0] red_out;
        logic [CH_W-1:0] green_out;
        logic [CH_W-1:0] blue_out;
        logic            frame_end;
    } t_pix_out;

    typedef struct packed {
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
    } t_rgb;

    localparam int PIX_W = $bits(t_rgb);

    typedef struct packed {
        t_rgb top;
        t_rgb mid;
        t_rgb bot;
    } t_col;

    typedef struct packed {
        logic [CSUM_W-1:0] r;
        logic [CSUM_W-1:0] g;
        logic [CSUM_W-1:0] b;
        logic [1:0]        cnt;
    } t_col_sum;

    typedef struct packed {
        logic top_ok;
        logic bot_ok;
        logic left_ok;
        logic right_ok;
        logic frame_end;
    } t_mask;

    typedef struct packed {
        logic shift;
        logic col_en;
        logic top_ok;
        logic bot_ok;
    } t_cell_ctl;

    // ceil(2^17 / (2n)): exact rounded quotient for numerators up to 511*n
    function automatic logic [RCP_W-1:0] recip(input logic [CNT_W-1:0] n);
        logic [RCP_W-1:0] m;
        unique case (n)
            4'd1:    m = 17'd65536;
            4'd2:    m = 17'd32768;
            4'd3:    m = 17'd21846;
            4'd4:    m = 17'd16384;
            4'd5:    m = 17'd13108;
            4'd6:    m = 17'd10923;
            4'd7:    m = 17'd9363;
            4'd8:    m = 17'd8192;
            4'd9:    m = 17'd7282;
            default: m = 17'd65536;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/bblur_ram.sv -----
// Generic single-write, single-read RAM with registered read data (read-first).
// Holds one line of pixels; no dependencies.
`default_nettype none

module bblur_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                        i_wdata,
    input  wire logic                                    i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

`default_nettype wire

// ----- rtl/core/bblur_cell.sv -----
// One column cell of the 3x3 window: holds three pixels, hands them to its
// older neighbor on each shift and gives its masked column sums. Uses bblur_pkg.
`default_nettype none

module bblur_cell (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire bblur_pkg::t_cell_ctl i_ctl,
    input  wire bblur_pkg::t_col      i_col,
    output bblur_pkg::t_col           o_col,
    output bblur_pkg::t_col_sum       o_sum
);
    import bblur_pkg::*;

    t_col r_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_ctl.shift) begin
            r_col <= i_col;
        end
    end

    function automatic logic [CSUM_W-1:0] csum(
        input logic [CH_W-1:0] a,
        input logic [CH_W-1:0] b,
        input logic [CH_W-1:0] c,
        input logic            use_a,
        input logic            use_c
    );
        logic [CSUM_W-1:0] s;
        s = CSUM_W'(b);
        if (use_a) s = s + CSUM_W'(a);
        if (use_c) s = s + CSUM_W'(c);
        return s;
    endfunction

    always_comb begin
        o_sum = '0;
        if (i_ctl.col_en) begin
            o_sum.r   = csum(r_col.top.r, r_col.mid.r, r_col.bot.r, i_ctl.top_ok, i_ctl.bot_ok);
            o_sum.g   = csum(r_col.top.g, r_col.mid.g, r_col.bot.g, i_ctl.top_ok, i_ctl.bot_ok);
            o_sum.b   = csum(r_col.top.b, r_col.mid.b, r_col.bot.b, i_ctl.top_ok, i_ctl.bot_ok);
            o_sum.cnt = 2'd1 + 2'(i_ctl.top_ok) + 2'(i_ctl.bot_ok);
        end
    end

    assign o_col = r_col;

endmodule

`default_nettype wire

// ----- rtl/core/bblur_mean.sv -----
// Rounded mean pipeline: adds the column sums, then divides by the pixel count
// through a reciprocal multiply. Two register stages. Uses bblur_pkg.
`default_nettype none

module bblur_mean (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire logic                i_frame_end,
    input  wire bblur_pkg::t_col_sum i_sums [3],
    output logic                     o_valid,
    output bblur_pkg::t_pix_out      o_item
);
    import bblur_pkg::*;

    logic [SUM_W-1:0]  a_sum_r, a_sum_g, a_sum_b;
    logic [CNT_W-1:0]  a_n;
    logic              r_a_valid;
    logic [SUM_W-1:0]  r_a_sum_r, r_a_sum_g, r_a_sum_b;
    logic [CNT_W-1:0]  r_a_n;
    logic              r_a_fe;

    logic [RCP_W-1:0]  b_rcp;
    logic [NUM_W-1:0]  b_num_r, b_num_g, b_num_b;
    logic              r_b_valid;
    logic [PROD_W-1:0] r_b_prod_r, r_b_prod_g, r_b_prod_b;
    logic              r_b_fe;

    always_comb begin
        a_sum_r = SUM_W'(i_sums[0].r) + SUM_W'(i_sums[1].r) + SUM_W'(i_sums[2].r);
        a_sum_g = SUM_W'(i_sums[0].g) + SUM_W'(i_sums[1].g) + SUM_W'(i_sums[2].g);
        a_sum_b = SUM_W'(i_sums[0].b) + SUM_W'(i_sums[1].b) + SUM_W'(i_sums[2].b);
        a_n     = CNT_W'(i_sums[0].cnt) + CNT_W'(i_sums[1].cnt) + CNT_W'(i_sums[2].cnt);
    end

    always_comb begin
        b_rcp   = recip(r_a_n);
        b_num_r = {r_a_sum_r, 1'b0} + NUM_W'(r_a_n);
        b_num_g = {r_a_sum_g, 1'b0} + NUM_W'(r_a_n);
        b_num_b = {r_a_sum_b, 1'b0} + NUM_W'(r_a_n);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
        end
        r_a_sum_r  <= a_sum_r;
        r_a_sum_g  <= a_sum_g;
        r_a_sum_b  <= a_sum_b;
        r_a_n      <= a_n;
        r_a_fe     <= i_frame_end;
        r_b_prod_r <= PROD_W'(b_num_r) * PROD_W'(b_rcp);
        r_b_prod_g <= PROD_W'(b_num_g) * PROD_W'(b_rcp);
        r_b_prod_b <= PROD_W'(b_num_b) * PROD_W'(b_rcp);
        r_b_fe     <= r_a_fe;
    end

    assign o_valid          = r_b_valid;
    assign o_item.red_out   = r_b_prod_r[RCP_SHIFT +: CH_W];
    assign o_item.green_out = r_b_prod_g[RCP_SHIFT +: CH_W];
    assign o_item.blue_out  = r_b_prod_b[RCP_SHIFT +: CH_W];
    assign o_item.frame_end = r_b_fe;

endmodule

`default_nettype wire

// ----- rtl/core/box_blur_3x3_edge_aware.sv -----
// Edge-aware 3x3 box blur on a raster RGB stream: stream control, two line RAMs,
// a row of three window cells, the mean pipeline and an output FIFO.
// Depends on bblur_pkg, bblur_ram, bblur_cell and bblur_mean.
//
// Usage: pixels of a frame enter on the in channel (command = pixel) in raster
// order; results leave on the out channel, one per pixel, in raster order.
// Result (R,C) is released by the item carrying pixel (R+1,C+1); after a frame's
// last pixel, drain items release the remaining results, one per drain item.
// Each released result passes the window stage registers, the mean pipeline
// and the result FIFO. Throughput is one item per cycle while o_in_ready is high,
// set by the window shift and one line RAM access per item. The first drain after
// a one-row frame needs a second window shift before its result is ready and
// holds the in channel off until then, longer while the FIFO is out of credit.
// Configuration writes (frame_width, frame_height) restart the stream; write
// them only when the block is idle. Reset loads 640 x 480 and clears the stream
// counters; the line RAMs are not cleared and need no clearing pass.
// A stalled receiver backs results into an 8-entry FIFO; input is also refused
// while 8 results are outstanding in the pipeline and FIFO together.
`default_nettype none

module box_blur_3x3_edge_aware #(
    parameter int MAX_WIDTH  = bblur_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bblur_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [bblur_pkg::CFG_IW-1:0]   i_cfg_idx,
    input  wire logic [bblur_pkg::CFG_DW-1:0]   i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire bblur_pkg::t_pix_in             i_in_item,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output bblur_pkg::t_pix_out                 o_out_item
);
    import bblur_pkg::*;

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W = $clog2(MAX_HEIGHT + 1);
    localparam int LAG_W = $clog2(MAX_WIDTH + 3);
    localparam int W_RST = (FW_RESET > MAX_WIDTH) ? MAX_WIDTH : FW_RESET;
    localparam int H_RST = (FH_RESET > MAX_HEIGHT) ? MAX_HEIGHT : FH_RESET;

    function automatic logic [WID_W-1:0] clamp_w(input logic [FW_W-1:0] v);
        logic [WID_W-1:0] res;
        if (v == '0) begin
            res = WID_W'(1);
        end else if (32'(v) > 32'(MAX_WIDTH)) begin
            res = WID_W'(MAX_WIDTH);
        end else begin
            res = WID_W'(v);
        end
        return res;
    endfunction

    function automatic logic [HGT_W-1:0] clamp_h(input logic [FH_W-1:0] v);
        logic [HGT_W-1:0] res;
        if (v == '0) begin
            res = HGT_W'(1);
        end else if (32'(v) > 32'(MAX_HEIGHT)) begin
            res = HGT_W'(MAX_HEIGHT);
        end else begin
            res = HGT_W'(v);
        end
        return res;
    endfunction

    logic [WID_W-1:0]  r_w_eff, n_w_eff;
    logic [HGT_W-1:0]  r_h_eff, n_h_eff;
    logic [COL_W-1:0]  r_in_col, n_in_col, r_out_col, n_out_col;
    logic [COL_W-1:0]  r_stream_col, n_stream_col;
    logic [ROW_W-1:0]  r_in_row, n_in_row, r_out_row, n_out_row;
    logic [LAG_W-1:0]  r_lag, n_lag, r_owed, n_owed;
    logic              r_flushing, n_flushing;
    logic              r_drain_busy, n_drain_busy;
    logic [PEND_W-1:0] r_pend, n_pend;

    logic [COL_W-1:0]  w_m1, addr, b_ocol, scol_nx;
    logic [ROW_W-1:0]  h_m1, b_orow;
    logic [LAG_W-1:0]  wp1, b_lag, b_owed, lag1, owed1, lag2, owed2;
    logic              accept, is_pix, drain_ok, busy_step, shift, clr;
    logic              emit, drain_done, credit_ok, pop;
    t_mask             mask;
    t_rgb              new_pix;

    logic              r_s1_shift, r_s1_emit, r_s1_byp;
    logic [COL_W-1:0]  r_s1_addr;
    t_rgb              r_s1_pix, r_s1_byp_top, r_s1_byp_mid;
    t_mask             r_s1_mask;
    logic              r_s2_emit;
    t_mask             r_s2_mask;
    logic [PIX_W-1:0]  older_q, newer_q;
    t_rgb              s1_top, s1_mid;

    t_col              cell_in  [3];
    t_col              cell_col [3];
    t_col_sum          col_sum  [3];
    t_cell_ctl         cell_ctl [3];

    logic              mean_valid;
    t_pix_out          mean_item;
    t_pix_out          r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp, r_rp;
    logic [PEND_W-1:0] r_fifo_cnt;

    assign credit_ok  = (r_pend != PEND_W'(FIFO_DEPTH));
    assign o_in_ready = !r_drain_busy && credit_ok;
    assign pop        = o_out_valid && i_out_ready;

    always_comb begin
        w_m1      = COL_W'(r_w_eff - WID_W'(1));
        h_m1      = ROW_W'(r_h_eff - HGT_W'(1));
        wp1       = LAG_W'(r_w_eff) + LAG_W'(1);
        accept    = i_in_valid && o_in_ready;
        is_pix    = accept && (i_in_item.command == CMD_PIXEL);
        drain_ok  = accept && (i_in_item.command == CMD_DRAIN) && (r_owed != '0)
                    && (r_in_col == '0) && (r_in_row == '0);
        busy_step = r_drain_busy && credit_ok;
        shift     = is_pix || drain_ok || busy_step;
        clr       = is_pix && r_flushing;

        b_lag  = clr ? '0 : r_lag;
        b_owed = clr ? '0 : r_owed;
        b_ocol = clr ? '0 : r_out_col;
        b_orow = clr ? '0 : r_out_row;
        addr   = clr ? r_in_col : r_stream_col;

        lag1       = b_lag + LAG_W'(1);
        owed1      = is_pix ? b_owed + LAG_W'(1) : b_owed;
        emit       = shift && (lag1 > wp1);
        lag2       = emit ? lag1 - LAG_W'(1) : lag1;
        owed2      = emit ? owed1 - LAG_W'(1) : owed1;
        drain_done = emit && !is_pix && (owed2 == '0);
        scol_nx    = (addr == w_m1) ? '0 : addr + COL_W'(1);

        mask.top_ok    = (b_orow != '0);
        mask.bot_ok    = (b_orow != h_m1);
        mask.left_ok   = (b_ocol != '0);
        mask.right_ok  = (b_ocol != w_m1);
        mask.frame_end = (b_orow == h_m1) && (b_ocol == w_m1);

        new_pix = '0;
        if (is_pix) begin
            new_pix.r = i_in_item.red_in;
            new_pix.g = i_in_item.green_in;
            new_pix.b = i_in_item.blue_in;
        end

        n_w_eff      = r_w_eff;
        n_h_eff      = r_h_eff;
        n_in_col     = r_in_col;
        n_in_row     = r_in_row;
        n_out_col    = b_ocol;
        n_out_row    = b_orow;
        n_stream_col = r_stream_col;
        n_lag        = r_lag;
        n_owed       = r_owed;
        n_flushing   = r_flushing;
        n_drain_busy = r_drain_busy;
        n_pend       = r_pend + PEND_W'(emit) - PEND_W'(pop);

        if (shift) begin
            n_stream_col = drain_done ? r_in_col : scol_nx;
            n_lag        = drain_done ? '0 : lag2;
            n_owed       = owed2;
        end
        if (is_pix) begin
            n_flushing = 1'b0;
            if (r_in_col == w_m1) begin
                n_in_col = '0;
                n_in_row = (r_in_row == h_m1) ? '0 : r_in_row + ROW_W'(1);
            end else begin
                n_in_col = r_in_col + COL_W'(1);
            end
        end
        if (drain_ok) begin
            n_flushing = 1'b1;
        end
        if (drain_ok || busy_step) begin
            n_drain_busy = !emit;
        end
        if (drain_done) begin
            n_flushing = 1'b0;
        end
        if (emit) begin
            if (b_ocol == w_m1) begin
                n_out_col = '0;
                n_out_row = (b_orow == h_m1) ? '0 : b_orow + ROW_W'(1);
            end else begin
                n_out_col = b_ocol + COL_W'(1);
            end
        end

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FRAME_WIDTH:  n_w_eff = clamp_w(i_cfg_data[FW_W-1:0]);
                REG_FRAME_HEIGHT: n_h_eff = clamp_h(i_cfg_data[FH_W-1:0]);
            endcase
            n_in_col     = '0;
            n_in_row     = '0;
            n_out_col    = '0;
            n_out_row    = '0;
            n_stream_col = '0;
            n_lag        = '0;
            n_owed       = '0;
            n_flushing   = 1'b0;
            n_drain_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_eff      <= WID_W'(W_RST);
            r_h_eff      <= HGT_W'(H_RST);
            r_in_col     <= '0;
            r_in_row     <= '0;
            r_out_col    <= '0;
            r_out_row    <= '0;
            r_stream_col <= '0;
            r_lag        <= '0;
            r_owed       <= '0;
            r_flushing   <= 1'b0;
            r_drain_busy <= 1'b0;
            r_pend       <= '0;
            r_s1_shift   <= 1'b0;
            r_s1_emit    <= 1'b0;
            r_s2_emit    <= 1'b0;
        end else begin
            r_w_eff      <= n_w_eff;
            r_h_eff      <= n_h_eff;
            r_in_col     <= n_in_col;
            r_in_row     <= n_in_row;
            r_out_col    <= n_out_col;
            r_out_row    <= n_out_row;
            r_stream_col <= n_stream_col;
            r_lag        <= n_lag;
            r_owed       <= n_owed;
            r_flushing   <= n_flushing;
            r_drain_busy <= n_drain_busy;
            r_pend       <= n_pend;
            r_s1_shift   <= shift;
            r_s1_emit    <= emit;
            r_s2_emit    <= r_s1_emit;
        end
        r_s1_addr    <= addr;
        r_s1_pix     <= new_pix;
        r_s1_mask    <= mask;
        r_s1_byp     <= r_s1_shift && (r_s1_addr == addr);
        r_s1_byp_top <= s1_mid;
        r_s1_byp_mid <= r_s1_pix;
        r_s2_mask    <= r_s1_mask;
    end

    // forward a same-address write from the previous shift
    assign s1_top = r_s1_byp ? r_s1_byp_top : t_rgb'(older_q);
    assign s1_mid = r_s1_byp ? r_s1_byp_mid : t_rgb'(newer_q);

    bblur_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_older (
        .i_clk   (i_clk),
        .i_we    (r_s1_shift),
        .i_waddr (r_s1_addr),
        .i_wdata (s1_mid),
        .i_re    (shift),
        .i_raddr (addr),
        .o_rdata (older_q)
    );

    bblur_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_newer (
        .i_clk   (i_clk),
        .i_we    (r_s1_shift),
        .i_waddr (r_s1_addr),
        .i_wdata (r_s1_pix),
        .i_re    (shift),
        .i_raddr (addr),
        .o_rdata (newer_q)
    );

    always_comb begin
        cell_in[2].top = s1_top;
        cell_in[2].mid = s1_mid;
        cell_in[2].bot = r_s1_pix;
        cell_in[1]     = cell_col[2];
        cell_in[0]     = cell_col[1];
        for (int j = 0; j < 3; j++) begin
            cell_ctl[j].shift  = r_s1_shift;
            cell_ctl[j].top_ok = r_s2_mask.top_ok;
            cell_ctl[j].bot_ok = r_s2_mask.bot_ok;
            cell_ctl[j].col_en = 1'b1;
        end
        cell_ctl[0].col_en = r_s2_mask.left_ok;
        cell_ctl[2].col_en = r_s2_mask.right_ok;
    end

    for (genvar j = 0; j < 3; j++) begin : g_cell
        bblur_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (cell_ctl[j]),
            .i_col   (cell_in[j]),
            .o_col   (cell_col[j]),
            .o_sum   (col_sum[j])
        );
    end

    bblur_mean u_mean (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_s2_emit),
        .i_frame_end (r_s2_mask.frame_end),
        .i_sums      (col_sum),
        .o_valid     (mean_valid),
        .o_item      (mean_item)
    );

    always_ff @(posedge i_clk) begin
        if (mean_valid) begin
            r_fifo[r_wp] <= mean_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp       <= '0;
            r_rp       <= '0;
            r_fifo_cnt <= '0;
        end else begin
            if (mean_valid) begin
                r_wp <= r_wp + FIFO_AW'(1);
            end
            if (pop) begin
                r_rp <= r_rp + FIFO_AW'(1);
            end
            r_fifo_cnt <= r_fifo_cnt + PEND_W'(mean_valid) - PEND_W'(pop);
        end
    end

    assign o_out_valid = (r_fifo_cnt != '0);
    assign o_out_item  = r_fifo[r_rp];

    a_owed_lag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_flushing |-> (r_owed == r_lag))
        else $error("owed and lag disagree outside a flush");

    a_stream_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_flushing |-> (r_stream_col == r_in_col))
        else $error("window column drifted from input column");

    a_busy_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drain_busy |-> r_flushing)
        else $error("drain sequencer busy outside a flush");

    a_fifo_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fifo_cnt <= r_pend) && (r_pend <= PEND_W'(FIFO_DEPTH)))
        else $error("outstanding result count out of range");

endmodule

`default_nettype wire

// ----- sim/blur_checker.sv -----
// Checker for the edge-aware 3x3 box blur: follows register writes and accepted items,
// predicts each blurred pixel and compares it field by field with the out channel.
// Depends on bblur_pkg only; watches the block's ports and drives nothing into it.
module blur_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bblur_pkg::CFG_IW-1:0]    i_cfg_idx,
    input  logic [bblur_pkg::CFG_DW-1:0]    i_cfg_data,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  bblur_pkg::t_pix_in              i_in_item,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  bblur_pkg::t_pix_out             i_out_item,
    output int                              o_errors,
    output int                              o_pending,
    output int                              o_items,
    output int                              o_results
);
    import bblur_pkg::*;

    localparam int LINE_LEN = DEF_MAX_WIDTH;
    localparam int ROWS_MAX = DEF_MAX_HEIGHT;

    logic [FW_W-1:0]  width_reg;
    logic [FH_W-1:0]  height_reg;
    logic [PIX_W-1:0] upper_line [LINE_LEN];
    logic [PIX_W-1:0] lower_line [LINE_LEN];
    logic [PIX_W-1:0] win [9];
    int unsigned      in_col, in_row, out_col, out_row;
    int unsigned      shift_col, owed_cnt, lag_cnt;
    bit               draining;
    t_pix_out         expected_means [$];
    int               err_cnt, item_cnt, result_cnt;

    function automatic int unsigned act_width();
        int unsigned w;
        w = width_reg;
        if (w == 0) w = 1;
        if (w > LINE_LEN) w = LINE_LEN;
        return w;
    endfunction

    function automatic int unsigned act_height();
        int unsigned h;
        h = height_reg;
        if (h == 0) h = 1;
        if (h > ROWS_MAX) h = ROWS_MAX;
        return h;
    endfunction

    function automatic logic [CH_W-1:0] rounded_mean(input int unsigned s, input int unsigned n);
        int unsigned q;
        q = (2 * s + n) / (2 * n);
        return q[CH_W-1:0];
    endfunction

    task automatic restart_stream();
        in_col    = 0;
        in_row    = 0;
        out_col   = 0;
        out_row   = 0;
        shift_col = 0;
        owed_cnt  = 0;
        lag_cnt   = 0;
        draining  = 1'b0;
    endtask

    task automatic shift_window(input logic [PIX_W-1:0] px);
        int unsigned      c;
        logic [PIX_W-1:0] px_up, px_mid;
        c = shift_col;
        if (c >= LINE_LEN) c = 0;
        px_up         = upper_line[c];
        px_mid        = lower_line[c];
        upper_line[c] = px_mid;
        lower_line[c] = px;
        for (int i = 0; i < 3; i++) begin
            win[3*i]   = win[3*i+1];
            win[3*i+1] = win[3*i+2];
        end
        win[2] = px_up;
        win[5] = px_mid;
        win[8] = px;
        c++;
        if (c >= act_width()) c = 0;
        shift_col = c;
        lag_cnt++;
    endtask

    task automatic emit_mean();
        int unsigned      w, h, sr, sg, sb, n;
        int               r, c;
        logic [PIX_W-1:0] p;
        t_pix_out         res;
        w  = act_width();
        h  = act_height();
        sr = 0;
        sg = 0;
        sb = 0;
        n  = 0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r = int'(out_row) + i - 1;
                c = int'(out_col) + j - 1;
                if (r >= 0 && c >= 0 && r < int'(h) && c < int'(w)) begin
                    p  = win[3*i+j];
                    sr += p[23:16];
                    sg += p[15:8];
                    sb += p[7:0];
                    n++;
                end
            end
        end
        if (n == 0) n = 1;
        res.red_out   = rounded_mean(sr, n);
        res.green_out = rounded_mean(sg, n);
        res.blue_out  = rounded_mean(sb, n);
        res.frame_end = (out_row + 1 == h) && (out_col + 1 == w);
        out_col++;
        if (out_col >= w) begin
            out_col = 0;
            out_row++;
            if (out_row >= h) out_row = 0;
        end
        if (lag_cnt > 0) lag_cnt--;
        if (owed_cnt > 0) owed_cnt--;
        expected_means.push_back(res);
    endtask

    task automatic predict_item(input t_pix_in item);
        int unsigned w;
        bit          done;
        w    = act_width();
        done = 1'b0;
        if (item.command == CMD_PIXEL) begin
            // a pixel cuts a partial flush short: drop what is still owed
            if (draining) begin
                owed_cnt  = 0;
                lag_cnt   = 0;
                out_col   = 0;
                out_row   = 0;
                draining  = 1'b0;
                shift_col = in_col;
            end
            shift_window({item.red_in, item.green_in, item.blue_in});
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
                if (in_row >= act_height()) in_row = 0;
            end
            owed_cnt++;
            if (lag_cnt > w + 1) emit_mean();
        end else if (owed_cnt != 0 && in_col == 0 && in_row == 0) begin
            draining = 1'b1;
            for (int unsigned k = 0; k < w + 2 && !done; k++) begin
                shift_window('0);
                if (lag_cnt > w + 1) begin
                    emit_mean();
                    if (owed_cnt == 0) begin
                        draining  = 1'b0;
                        lag_cnt   = 0;
                        shift_col = in_col;
                    end
                    done = 1'b1;
                end
            end
        end
    endtask

    task automatic check_result(input t_pix_out got);
        t_pix_out want;
        if (expected_means.size() == 0) begin
            $error("blurred pixel with no expectation waiting: %h", got);
            err_cnt++;
        end else begin
            want = expected_means.pop_front();
            if (got.red_out !== want.red_out) begin
                $error("red_out: expected %0d, actual %0d", want.red_out, got.red_out);
                err_cnt++;
            end
            if (got.green_out !== want.green_out) begin
                $error("green_out: expected %0d, actual %0d", want.green_out, got.green_out);
                err_cnt++;
            end
            if (got.blue_out !== want.blue_out) begin
                $error("blue_out: expected %0d, actual %0d", want.blue_out, got.blue_out);
                err_cnt++;
            end
            if (got.frame_end !== want.frame_end) begin
                $error("frame_end: expected %0d, actual %0d", want.frame_end, got.frame_end);
                err_cnt++;
            end
        end
        result_cnt++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg  = FW_W'(FW_RESET);
            height_reg = FH_W'(FH_RESET);
            for (int i = 0; i < LINE_LEN; i++) begin
                upper_line[i] = '0;
                lower_line[i] = '0;
            end
            for (int i = 0; i < 9; i++) win[i] = '0;
            restart_stream();
            expected_means.delete();
            err_cnt    = 0;
            item_cnt   = 0;
            result_cnt = 0;
        end else begin
            if (i_out_valid && i_out_ready) check_result(i_out_item);
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_FRAME_WIDTH) begin
                    width_reg = i_cfg_data[FW_W-1:0];
                    restart_stream();
                end else if (i_cfg_idx == REG_FRAME_HEIGHT) begin
                    height_reg = i_cfg_data[FH_W-1:0];
                    restart_stream();
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_item(i_in_item);
                item_cnt++;
            end
        end
        o_errors  <= err_cnt;
        o_pending <= expected_means.size();
        o_items   <= item_cnt;
        o_results <= result_cnt;
    end

endmodule

// ----- sim/box_blur_3x3_edge_aware_tb.sv -----
// Testbench top for the edge-aware 3x3 box blur: clock, reset, register writes,
// bursty pixel and drain stimulus, a stalling receiver, watchdog and verdict.
// Depends on bblur_pkg, box_blur_3x3_edge_aware and blur_checker.
module box_blur_3x3_edge_aware_tb;
    import bblur_pkg::*;

    localparam int IDLE_LIMIT    = 4000;
    localparam int SETTLE_CYCLES = 20;
    localparam int RANDOM_PIXELS = 200;
    localparam int HOLD_CYCLES   = 250;
    localparam int FRAME_CAP     = 150;
    localparam int BIG_PIXELS    = 1032;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                cfg_we   = 1'b0;
    logic [CFG_IW-1:0]   cfg_idx  = '0;
    logic [CFG_DW-1:0]   cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    t_pix_in             in_item  = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    t_pix_out            out_item;

    int                  mismatches, pending, items_seen, results_seen;
    int                  idle_cycles   = 0;
    int                  burst_left    = 0;
    int                  pixels_sent   = 0;
    int                  settings_cnt  = 0;
    bit                  stall_request = 1'b0;
    int                  hold_left     = 0;
    bit                  hold_done     = 1'b0;
    int                  seg_left      = 0;
    int                  ready_pct     = 100;

    always #4 clk = ~clk;

    box_blur_3x3_edge_aware u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    blur_checker u_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_item  (out_item),
        .o_errors    (mismatches),
        .o_pending   (pending),
        .o_items     (items_seen),
        .o_results   (results_seen)
    );

    // receiver: one long hold-off on request, otherwise segments of varying readiness
    always @(posedge clk) begin
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else if (stall_request && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            out_ready <= 1'b0;
        end else begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(8, 80);
                case ($urandom_range(0, 3))
                    0: ready_pct = 100;
                    1: ready_pct = 75;
                    2: ready_pct = 50;
                    default: ready_pct = 15;
                endcase
            end
            seg_left--;
            out_ready <= ($urandom_range(1, 100) <= ready_pct);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int unsigned eff_size(input int unsigned v, input int unsigned lim);
        if (v == 0) return 1;
        if (v > lim) return lim;
        return v;
    endfunction

    function automatic logic [CH_W-1:0] pick_level();
        int unsigned r;
        r = $urandom_range(0, 7);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return CH_W'($urandom_range(0, 255));
    endfunction

    task automatic push_item(input t_pix_in item);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        burst_left--;
        if (item.command == CMD_PIXEL) pixels_sent++;
    endtask

    task automatic send_pixel(input logic [CH_W-1:0] r, g, b);
        t_pix_in item;
        item.command  = CMD_PIXEL;
        item.red_in   = r;
        item.green_in = g;
        item.blue_in  = b;
        push_item(item);
    endtask

    task automatic send_drain(input int n);
        t_pix_in item;
        repeat (n) begin
            item.command  = CMD_DRAIN;
            item.red_in   = CH_W'($urandom_range(0, 255));
            item.green_in = CH_W'($urandom_range(0, 255));
            item.blue_in  = CH_W'($urandom_range(0, 255));
            push_item(item);
        end
    endtask

    task automatic send_pixels(input int n, input bit noisy);
        repeat (n) begin
            if (noisy && $urandom_range(0, 29) == 0) send_drain(1);
            send_pixel(pick_level(), pick_level(), pick_level());
        end
    endtask

    // hold input, wait for every owed result, then let the pipeline go quiet
    task automatic settle();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_regs(input bit do_w, input logic [CFG_DW-1:0] w,
                              input bit do_h, input logic [CFG_DW-1:0] h);
        if (do_w) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= REG_FRAME_WIDTH;
            cfg_data <= w;
            @(posedge clk);
        end
        if (do_h) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= REG_FRAME_HEIGHT;
            cfg_data <= h;
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        settings_cnt++;
    endtask

    initial begin
        logic [CFG_DW-1:0] reg_w, reg_h, wv, hv;
        bit                do_w, do_h, partial;
        int unsigned       we, he, npx;
        int                frames, phase_no, ending;

        reg_w    = CFG_DW'(FW_RESET);
        reg_h    = CFG_DW'(FH_RESET);
        phase_no = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 3x2 frame: channel extremes, a drain mid-frame, full flush plus one spare drain
        write_regs(1'b1, 13'd3, 1'b1, 13'd2);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd85, 8'd170, 8'd15);
        send_drain(1);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd1, 8'd128, 8'd254);
        send_drain(5);
        settle();

        // zero registers act as a 1x1 frame
        write_regs(1'b1, 13'd0, 1'b1, 13'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_drain(2);
        send_pixel(8'd128, 8'd127, 8'd1);
        send_drain(1);
        settle();

        // one-row frame, then a pixel that interrupts the flush
        write_regs(1'b1, 13'd4, 1'b1, 13'd1);
        send_pixels(4, 1'b0);
        send_drain(1);
        send_pixel(8'd200, 8'd100, 8'd50);
        settle();

        pixels_sent = 0;
        while (pixels_sent < RANDOM_PIXELS || phase_no < 3) begin
            if (phase_no == 2) begin
                do_w   = 1'b1;
                do_h   = 1'b1;
                wv     = 13'd2;
                hv     = 13'd4;
                frames = 5;
            end else begin
                do_w = ($urandom_range(0, 3) != 0);
                do_h = !do_w || ($urandom_range(0, 1) == 0);
                case ($urandom_range(0, 19))
                    0: wv = 13'd0;
                    1: wv = 13'd1;
                    2: wv = CFG_DW'($urandom_range(1025, 2047));
                    3, 4: wv = CFG_DW'($urandom_range(17, 40));
                    default: wv = CFG_DW'($urandom_range(2, 8));
                endcase
                case ($urandom_range(0, 19))
                    0: hv = 13'd0;
                    1, 2: hv = 13'd1;
                    3: hv = CFG_DW'($urandom_range(4097, 8191));
                    default: hv = CFG_DW'($urandom_range(2, 6));
                endcase
                frames = $urandom_range(1, 4);
            end
            write_regs(do_w, wv, do_h, hv);
            if (do_w) reg_w = wv;
            if (do_h) reg_h = hv;
            if (phase_no == 2) stall_request <= 1'b1;
            we      = eff_size(reg_w[FW_W-1:0], DEF_MAX_WIDTH);
            he      = eff_size(reg_h[FH_W-1:0], DEF_MAX_HEIGHT);
            npx     = we * he;
            partial = (npx > FRAME_CAP);
            if (partial) begin
                send_pixels($urandom_range(1, FRAME_CAP), 1'b1);
                send_drain($urandom_range(0, 2));
            end else begin
                for (int f = 0; f < frames; f++) begin
                    send_pixels(npx, 1'b1);
                    ending = (f == frames - 1) ? 0 : $urandom_range(0, 2);
                    case (ending)
                        0: send_drain(we + 2 + $urandom_range(0, 2));
                        1: send_drain($urandom_range(1, we));
                        default: ;
                    endcase
                end
            end
            settle();
            phase_no++;
        end

        // widest and tallest frame: enough rows to reach the far end of the line stores
        write_regs(1'b1, CFG_DW'(DEF_MAX_WIDTH), 1'b1, CFG_DW'(DEF_MAX_HEIGHT));
        send_pixels(BIG_PIXELS, 1'b0);
        send_drain(1);
        settle();

        $display("Run covered %0d items over %0d register settings, including one long receiver",
                 items_seen, settings_cnt);
        $display("hold-off and a full-width frame; %0d blurred pixels compared, %0d mismatches.",
                 results_seen, mismatches);
        if (mismatches == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
